>>> sv/analog_out_two_point_calibrator_defines.svh
// Assertion macros for the analog output two point calibrator.
// Included by the top level; depends on nothing else.
`ifndef ANALOG_OUT_TWO_POINT_CALIBRATOR_DEFINES_SVH
`define ANALOG_OUT_TWO_POINT_CALIBRATOR_DEFINES_SVH
`ifndef ASSERT_OFF
`define AOTPC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
`define AOTPC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define AOTPC_ASSERT_NOW(lbl, ante, cons, msg)
`define AOTPC_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

>>> sv/aotpc_pkg.sv
// Shared types and constants for the analog output two point calibrator.
// No dependencies; used by every module of the block.
package aotpc_pkg;

  localparam int PWM_MAX_DEF = 4096;

  localparam int DIV_W  = 41;  // dividend and quotient width
  localparam int DIV_VW = 16;  // divisor width

  localparam logic [1:0] FN_OUTPUT = 2'd0;
  localparam logic [1:0] FN_CAL    = 2'd1;
  localparam logic [1:0] FN_RESET  = 2'd2;
  localparam logic [1:0] FN_UNUSED = 2'd3;

  localparam logic [23:0] GAIN_RESET = 24'd1677722;
  localparam logic [15:0] TRIM_LOWER = 16'd4000;
  localparam logic [15:0] TRIM_UPPER = 16'd20000;
  localparam int          TRIM_SPAN  = 16000;
  localparam int          OFFS_LIMIT = 768000;
  localparam int          GAIN_LOW   = 1342177;
  localparam int          GAIN_HIGH  = 2181039;
  localparam logic [4:0]  ST_LOWER   = 5'h01;
  localparam logic [4:0]  ST_UPPER   = 5'h10;

  // 2^39 / 125 rounded up, less 2^32. After a shift by 7 this divides a
  // 32-bit value by 125, so the pair divides by the trim span exactly.
  localparam logic [26:0] SPAN_RECIP = 27'd103079216;

  typedef struct packed {
    logic [1:0]         func;
    logic               channel;
    logic signed [15:0] drive_value;
    logic [15:0]        trim_point;
    logic [15:0]        measured;
  } in_item_t;

  typedef struct packed {
    logic [11:0] pwm_level;
    logic        out_channel;
    logic        point_handled;
    logic        cal_accepted;
    logic [4:0]  cal_status;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_START_G,
    ST_DIV_G,
    ST_START_O,
    ST_DIV_O,
    ST_FIN
  } ctrl_state_t;

  typedef struct packed {
    logic ld_in;
    logic mul_en;
    logic div_start;
    logic ofs_ld;    // register the scaled offset dividend
    logic ofs_mul;   // register the offset quotient
    logic commit;
  } dp_cmd_t;

  typedef struct packed {
    logic need_div;
    logic div_done;
  } dp_status_t;

endpackage

>>> sv/aotpc_div.sv
// Bit-serial restoring divider, one quotient bit per cycle.
// Depends on aotpc_pkg for the default widths.
module aotpc_div #(
  parameter int DW = aotpc_pkg::DIV_W,
  parameter int VW = aotpc_pkg::DIV_VW
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [DW-1:0] dividend,
  input  logic [VW-1:0] divisor,
  output logic          done,
  output logic [DW-1:0] quotient
);
  localparam int CW = $clog2(DW + 1);

  logic [DW-1:0] quo_r, quo_nxt;
  logic [VW-1:0] rem_r, rem_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          active_r, active_nxt;
  logic          done_r, done_nxt;
  logic [VW:0]   trial;
  logic          fits;

  assign trial = {rem_r, quo_r[DW-1]};
  assign fits  = trial >= {1'b0, divisor};

  always_comb begin
    quo_nxt    = quo_r;
    rem_nxt    = rem_r;
    cnt_nxt    = cnt_r;
    active_nxt = active_r;
    done_nxt   = 1'b0;
    if (start) begin
      quo_nxt    = dividend;
      rem_nxt    = '0;
      cnt_nxt    = CW'(DW);
      active_nxt = 1'b1;
    end else if (active_r) begin
      quo_nxt = {quo_r[DW-2:0], fits};
      rem_nxt = fits ? VW'(trial - {1'b0, divisor}) : trial[VW-1:0];
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CW'(1)) begin
        active_nxt = 1'b0;
        done_nxt   = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    cnt_r <= cnt_nxt;
    if (!rst_n) begin
      active_r <= 1'b0;
      done_r   <= 1'b0;
    end else begin
      active_r <= active_nxt;
      done_r   <= done_nxt;
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;
endmodule

>>> sv/aotpc_dp.sv
// Datapath: channel calibration store, multipliers, gain divider, result register.
// Depends on aotpc_pkg and aotpc_div.
module aotpc_dp #(
  parameter int PWM_MAX = aotpc_pkg::PWM_MAX_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  aotpc_pkg::in_item_t   in_data,
  input  aotpc_pkg::dp_cmd_t    cmd,
  output aotpc_pkg::dp_status_t status,
  output aotpc_pkg::out_item_t  out_data
);
  import aotpc_pkg::*;

  logic [1:0]         func_r;
  logic               ch_r;
  logic signed [15:0] drive_r;
  logic [15:0]        trim_r;
  logic [15:0]        meas_r;

  logic [23:0]        gain_r [2];
  logic signed [23:0] offs_r [2];
  logic [4:0]         stat_r [2];

  logic signed [48:0] prod_out_r;
  logic [38:0]        prod_g_r;
  logic signed [41:0] prod_o_r;
  logic [DIV_W-1:0]   q_g_r;
  logic [31:0]        ofs_y_r;
  logic [27:0]        q_o_r;
  out_item_t          out_r;

  logic               is_lower, is_upper, handled, d_pos, ok;
  logic signed [17:0] d_s;
  logic [15:0]        d_u;
  logic [23:0]        gain_sel;
  logic signed [23:0] offs_sel;
  logic signed [24:0] sum_out, base, sum_base;
  logic signed [48:0] mul_out;
  logic signed [41:0] mul_o;
  logic [38:0]        mul_g;
  logic [41:0]        o_abs;
  logic [41:0]        o_round;
  logic [31:0]        ofs_y;
  logic [58:0]        recip_lo;
  logic [64:0]        recip;
  logic [DIV_W-1:0]   div_dividend, div_q;
  logic [DIV_VW-1:0]  div_divisor;
  logic               div_done;
  logic signed [29:0] q_o_s, new_offs;
  logic [16:0]        lvl;
  logic [11:0]        level;
  logic [4:0]         new_stat;
  logic [4:0]         trim_bit;

  assign is_lower = trim_r == TRIM_LOWER;
  assign is_upper = trim_r == TRIM_UPPER;
  assign handled  = (func_r == FN_CAL) && (is_lower || is_upper);
  assign d_s      = is_lower ? (18'sd20000 - $signed({2'b00, meas_r}))
                             : ($signed({2'b00, meas_r}) - 18'sd4000);
  assign d_pos    = !d_s[17] && (d_s != 18'sd0);
  assign d_u      = d_s[15:0];
  assign gain_sel = gain_r[ch_r];
  assign offs_sel = offs_r[ch_r];

  assign sum_out  = $signed({drive_r[15], drive_r, 8'h00}) + 25'(offs_sel);
  assign mul_out  = sum_out * $signed({1'b0, gain_sel});
  assign base     = is_lower ? 25'sd1024000 : 25'sd5120000;
  assign sum_base = base + 25'(offs_sel);
  assign mul_o    = sum_base * $signed({1'b0, d_u});
  assign mul_g    = 39'(gain_sel) * 39'(TRIM_SPAN) + 39'(d_u[15:1]);

  assign div_dividend = DIV_W'(prod_g_r);
  assign div_divisor  = d_u;

  aotpc_div #(.DW(DIV_W), .VW(DIV_VW)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_q)
  );

  // Rounding half away from zero works on the magnitude. The rounded
  // magnitude stays below 2^39, so after the shift by 7 it fits 32 bits
  // and the reciprocal product finishes the division by 125.
  assign o_abs    = prod_o_r[41] ? 42'(-prod_o_r) : 42'(prod_o_r);
  assign o_round  = o_abs + 42'(TRIM_SPAN / 2);
  assign ofs_y    = o_round[38:7];
  assign recip_lo = ofs_y_r * SPAN_RECIP;
  assign recip    = {1'b0, ofs_y_r, 32'd0} + {6'd0, recip_lo};

  assign q_o_s    = prod_o_r[41] ? -$signed({2'b00, q_o_r})
                                 : $signed({2'b00, q_o_r});
  assign new_offs = q_o_s - $signed({6'd0, meas_r, 8'h00});
  assign ok = d_pos && (new_offs > -30'(OFFS_LIMIT)) && (new_offs < 30'(OFFS_LIMIT))
           && (q_g_r > DIV_W'(GAIN_LOW)) && (q_g_r < DIV_W'(GAIN_HIGH));

  assign lvl = prod_out_r[48:32] + 17'(prod_out_r[31]);
  always_comb begin
    if (func_r != FN_OUTPUT || prod_out_r <= 49'sd0) begin
      level = '0;
    end else if (lvl >= 17'(PWM_MAX - 1)) begin
      level = 12'(PWM_MAX - 1);
    end else begin
      level = lvl[11:0];
    end
  end

  assign trim_bit = is_lower ? ST_LOWER : ST_UPPER;
  always_comb begin
    new_stat = stat_r[ch_r];
    if (func_r == FN_RESET) begin
      new_stat = '0;
    end else if (handled) begin
      new_stat = ok ? (stat_r[ch_r] | trim_bit) : 5'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.ld_in) begin
      func_r  <= in_data.func;
      ch_r    <= in_data.channel;
      drive_r <= in_data.drive_value;
      trim_r  <= in_data.trim_point;
      meas_r  <= in_data.measured;
    end
    if (cmd.mul_en) begin
      prod_out_r <= mul_out;
      prod_g_r   <= mul_g;
      prod_o_r   <= mul_o;
    end
    if (div_done)    q_g_r   <= div_q;
    if (cmd.ofs_ld)  ofs_y_r <= ofs_y;
    if (cmd.ofs_mul) q_o_r   <= {2'b00, recip[64:39]};
    if (cmd.commit) begin
      out_r.pwm_level     <= level;
      out_r.out_channel   <= ch_r;
      out_r.point_handled <= handled;
      out_r.cal_accepted  <= handled && ok;
      out_r.cal_status    <= new_stat;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 2; i++) begin
        gain_r[i] <= GAIN_RESET;
        offs_r[i] <= '0;
        stat_r[i] <= '0;
      end
    end else if (cmd.commit) begin
      stat_r[ch_r] <= new_stat;
      if (func_r == FN_RESET) begin
        gain_r[ch_r] <= GAIN_RESET;
        offs_r[ch_r] <= '0;
      end else if (handled && ok) begin
        gain_r[ch_r] <= q_g_r[23:0];
        offs_r[ch_r] <= new_offs[23:0];
      end
    end
  end

  assign status.need_div = handled && d_pos;
  assign status.div_done = div_done;
  assign out_data        = out_r;
endmodule

>>> sv/aotpc_ctrl.sv
// Controller state machine: sequences capture, multiply, divisions and commit.
// Depends on aotpc_pkg.
module aotpc_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  output logic                  out_valid,
  input  logic                  out_ready,
  input  aotpc_pkg::dp_status_t status,
  output aotpc_pkg::dp_cmd_t    cmd
);
  import aotpc_pkg::*;

  ctrl_state_t state_r, state_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic        out_free;

  assign out_free = !out_valid_r || out_ready;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:    if (in_valid) state_nxt = ST_EXEC;
      ST_EXEC:    state_nxt = status.need_div ? ST_START_G : ST_FIN;
      ST_START_G: state_nxt = ST_DIV_G;
      ST_DIV_G:   if (status.div_done) state_nxt = ST_START_O;
      ST_START_O: state_nxt = ST_DIV_O;
      ST_DIV_O:   state_nxt = ST_FIN;
      ST_FIN:     if (out_free) state_nxt = ST_IDLE;
      default:    state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready   = 1'b1;
        cmd.ld_in  = in_valid;
      end
      ST_EXEC:    cmd.mul_en = 1'b1;
      ST_START_G: cmd.div_start = 1'b1;
      ST_DIV_G:   cmd = '0;
      ST_START_O: cmd.ofs_ld = 1'b1;
      ST_DIV_O:   cmd.ofs_mul = 1'b1;
      ST_FIN:     cmd.commit = out_free;
      default:    cmd = '0;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.commit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;
endmodule

>>> sv/analog_out_two_point_calibrator.sv
// Top level of the analog output two point calibrator.
// Depends on aotpc_pkg, aotpc_ctrl, aotpc_dp and the assertion macro header.
//
// Two-channel gain/offset calibrator. Each transaction carries one request:
// output (level = round((drive_value + offset) * gain), clamped to
// 0..PWM_MAX-1), calibrate at trim point 4000 or 20000, or channel reset.
// One request is in work at a time. Output, reset and unhandled requests
// pass through capture, multiply and commit; a calibrate request that
// reaches the divider also waits on the bit-serial gain divider, which
// produces one quotient bit per cycle over a 41-bit division. The offset
// division by the trim span is a reciprocal multiplication, registering
// the shifted dividend and then the quotient. A new request is accepted
// while the previous result waits in the output register.
`include "analog_out_two_point_calibrator_defines.svh"
module analog_out_two_point_calibrator #(
  parameter int PWM_MAX = aotpc_pkg::PWM_MAX_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  aotpc_pkg::in_item_t  in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output aotpc_pkg::out_item_t out_data
);
  import aotpc_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  aotpc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  aotpc_dp #(.PWM_MAX(PWM_MAX)) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_data  (in_data),
    .cmd      (cmd),
    .status   (status),
    .out_data (out_data)
  );

  `AOTPC_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready, "ready after accept")
  `AOTPC_ASSERT_NOW(a_accept_needs_point, out_valid && out_data.cal_accepted, out_data.point_handled, "accepted without point")
  `AOTPC_ASSERT_NOW(a_accept_sets_status, out_valid && out_data.cal_accepted, out_data.cal_status != 5'd0, "accepted with empty status")
  `AOTPC_ASSERT_NOW(a_cal_no_level, out_valid && out_data.point_handled, out_data.pwm_level == 12'd0, "level on calibrate")
endmodule

>>> dv/analog_out_two_point_calibrator_tb.sv
// Self-checking testbench for the analog output two point calibrator.
// Depends on aotpc_pkg and the top level; predicts each result in a local model.
module analog_out_two_point_calibrator_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import aotpc_pkg::*;

  localparam int PWM_MAX = PWM_MAX_DEF;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int IN_W = $bits(in_item_t);

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_ready;
  out_item_t out_data;

  analog_out_two_point_calibrator #(.PWM_MAX(PWM_MAX)) i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  // Predicted calibration state of both channels.
  logic [23:0] cal_gain [2];
  logic signed [31:0] cal_offset [2];
  logic [4:0] cal_stat [2];

  in_item_t  pending_items [$];
  out_item_t expected_results [$];
  int        error_count;
  int        hold_off_cycles;
  int        idle_cycles;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic longint div_half_away(longint num, longint den);
    longint mag;
    longint q;
    mag = (num < 0) ? -num : num;
    q = (mag + den / 2) / den;
    return (num < 0) ? -q : q;
  endfunction

  function automatic out_item_t predict_result(in_item_t item);
    out_item_t res;
    longint p;
    longint lvl;
    longint d;
    longint base;
    longint ng;
    longint no;
    bit lower;
    bit ok;
    logic ch;
    res = '0;
    ch = item.channel;
    res.out_channel = item.channel;
    if (item.func == FN_OUTPUT) begin
      p = (longint'(item.drive_value) * 256 + cal_offset[ch]) * longint'(cal_gain[ch]);
      if (p > 0) begin
        lvl = (p + (64'sd1 <<< 31)) >>> 32;
        if (lvl >= PWM_MAX - 1) lvl = PWM_MAX - 1;
        res.pwm_level = lvl[11:0];
      end
    end else if (item.func == FN_CAL) begin
      if (item.trim_point == TRIM_LOWER || item.trim_point == TRIM_UPPER) begin
        lower = (item.trim_point == TRIM_LOWER);
        d = lower ? (20000 - longint'(item.measured)) : (longint'(item.measured) - 4000);
        base = lower ? 4000 : 20000;
        ok = 1'b0;
        res.point_handled = 1'b1;
        cal_stat[ch] |= lower ? ST_LOWER : ST_UPPER;
        if (d > 0) begin
          ng = div_half_away(longint'(TRIM_SPAN) * longint'(cal_gain[ch]), d);
          no = div_half_away((base * 256 + cal_offset[ch]) * d, TRIM_SPAN)
               - longint'(item.measured) * 256;
          ok = (no > -OFFS_LIMIT) && (no < OFFS_LIMIT) && (ng > GAIN_LOW) && (ng < GAIN_HIGH);
        end
        if (ok) begin
          cal_gain[ch] = ng[23:0];
          cal_offset[ch] = no[31:0];
          res.cal_accepted = 1'b1;
        end else begin
          cal_stat[ch] = '0;
        end
      end
    end else if (item.func == FN_RESET) begin
      cal_gain[ch] = GAIN_RESET;
      cal_offset[ch] = 0;
      cal_stat[ch] = '0;
    end
    res.cal_status = cal_stat[ch];
    return res;
  endfunction

  function automatic in_item_t make_item(logic [1:0] fn, logic ch, logic [15:0] drv,
                                         logic [15:0] trim, logic [15:0] meas);
    in_item_t it;
    it.func = fn;
    it.channel = ch;
    it.drive_value = drv;
    it.trim_point = trim;
    it.measured = meas;
    return it;
  endfunction

  // Measured values near the ideal line keep calibrations mostly valid.
  function automatic in_item_t random_item();
    in_item_t it;
    int sel;
    it = IN_W'({$urandom, $urandom});
    sel = $urandom_range(0, 99);
    if (sel < 45) begin
      it.func = FN_OUTPUT;
      if ($urandom_range(0, 1)) it.drive_value = 16'($urandom_range(0, 40000));
    end else if (sel < 85) begin
      it.func = FN_CAL;
      if ($urandom_range(0, 9) != 0) begin
        it.trim_point = $urandom_range(0, 1) ? TRIM_LOWER : TRIM_UPPER;
        if ($urandom_range(0, 4) != 0)
          it.measured = (it.trim_point == TRIM_LOWER) ? 16'(3700 + $urandom_range(0, 600))
                                                      : 16'(19500 + $urandom_range(0, 1000));
      end
    end else if (sel < 95) begin
      it.func = FN_RESET;
    end else begin
      it.func = FN_UNUSED;
    end
    return it;
  endfunction

  function automatic int predict_and_push(in_item_t item);
    expected_results.push_back(predict_result(item));
    return 0;
  endfunction

  // Driver: bursts with random gaps; valid holds until the transaction completes.
  int burst_left;
  int gap_left;
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      burst_left <= 0;
      gap_left <= 0;
    end else if (!in_valid || in_ready) begin
      if (in_valid && in_ready) void'(predict_and_push(in_data));
      if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        in_valid <= 1'b0;
      end else if (pending_items.size() > 0) begin
        in_data <= pending_items.pop_front();
        in_valid <= 1'b1;
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 30);
          gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 12);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver stall pattern, with a long hold-off counted here.
  int stall_phase;
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      stall_phase <= 0;
      hold_off_cycles <= 0;
    end else begin
      stall_phase <= stall_phase + 1;
      if (hold_off_cycles > 0) begin
        hold_off_cycles <= hold_off_cycles - 1;
        out_ready <= 1'b0;
      end else if (stall_phase == 3000) begin
        hold_off_cycles <= 400;
        out_ready <= 1'b0;
      end else if ((stall_phase / 500) % 2 == 0) begin
        out_ready <= 1'b1;
      end else begin
        out_ready <= ($urandom_range(0, 99) < 60);
      end
    end
  end

  // Monitor: compare each result with the oldest expectation.
  always @(posedge clk) begin
    out_item_t exp_res;
    if (!rst_n) begin
      idle_cycles <= 0;
    end else begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result %p", $realtime, out_data);
          error_count++;
        end else begin
          exp_res = expected_results.pop_front();
          if (exp_res.pwm_level !== out_data.pwm_level)
            $display("%0t: pwm_level expected %0d actual %0d", $realtime,
                     exp_res.pwm_level, out_data.pwm_level);
          if (exp_res.out_channel !== out_data.out_channel)
            $display("%0t: out_channel expected %0d actual %0d", $realtime,
                     exp_res.out_channel, out_data.out_channel);
          if (exp_res.point_handled !== out_data.point_handled)
            $display("%0t: point_handled expected %0d actual %0d", $realtime,
                     exp_res.point_handled, out_data.point_handled);
          if (exp_res.cal_accepted !== out_data.cal_accepted)
            $display("%0t: cal_accepted expected %0d actual %0d", $realtime,
                     exp_res.cal_accepted, out_data.cal_accepted);
          if (exp_res.cal_status !== out_data.cal_status)
            $display("%0t: cal_status expected %0h actual %0h", $realtime,
                     exp_res.cal_status, out_data.cal_status);
          if (exp_res !== out_data) error_count++;
        end
      end
    end
  end

  initial begin
    error_count = 0;
    in_data = '0;
    for (int c = 0; c < 2; c++) begin
      cal_gain[c] = GAIN_RESET;
      cal_offset[c] = 0;
      cal_stat[c] = '0;
    end
    // Directed part: field extremes, every operation, special trim cases.
    pending_items.push_back(make_item(FN_OUTPUT, 1'b0, 16'h7fff, 16'h0, 16'h0));
    pending_items.push_back(make_item(FN_OUTPUT, 1'b1, 16'h8000, 16'hffff, 16'hffff));
    pending_items.push_back(make_item(FN_OUTPUT, 1'b0, 16'd0, 16'h0, 16'h0));
    pending_items.push_back(make_item(FN_OUTPUT, 1'b0, 16'd5, 16'h0, 16'h0));
    pending_items.push_back(make_item(FN_CAL, 1'b0, 16'h0, TRIM_LOWER, 16'd4000));
    pending_items.push_back(make_item(FN_CAL, 1'b0, 16'h0, TRIM_UPPER, 16'd20000));
    pending_items.push_back(make_item(FN_CAL, 1'b1, 16'h0, TRIM_LOWER, 16'd3900));
    pending_items.push_back(make_item(FN_CAL, 1'b1, 16'h0, TRIM_UPPER, 16'd20100));
    pending_items.push_back(make_item(FN_OUTPUT, 1'b1, 16'd20000, 16'h0, 16'h0));
    // Zero and negative divisors.
    pending_items.push_back(make_item(FN_CAL, 1'b0, 16'h0, TRIM_LOWER, 16'd20000));
    pending_items.push_back(make_item(FN_CAL, 1'b0, 16'h0, TRIM_UPPER, 16'd4000));
    pending_items.push_back(make_item(FN_CAL, 1'b0, 16'h0, TRIM_LOWER, 16'hffff));
    pending_items.push_back(make_item(FN_CAL, 1'b1, 16'h0, TRIM_UPPER, 16'd0));
    // Gain and offset out of range, and trim points that are not handled.
    pending_items.push_back(make_item(FN_CAL, 1'b0, 16'h0, TRIM_UPPER, 16'd10000));
    pending_items.push_back(make_item(FN_CAL, 1'b0, 16'h0, TRIM_LOWER, 16'd8000));
    pending_items.push_back(make_item(FN_CAL, 1'b1, 16'h0, 16'd4001, 16'd4000));
    pending_items.push_back(make_item(FN_CAL, 1'b1, 16'h0, 16'd0, 16'd0));
    pending_items.push_back(make_item(FN_RESET, 1'b1, 16'h0, 16'h0, 16'h0));
    pending_items.push_back(make_item(FN_UNUSED, 1'b0, 16'hffff, 16'hffff, 16'hffff));
    pending_items.push_back(make_item(FN_OUTPUT, 1'b1, 16'h7fff, 16'h0, 16'h0));
    for (int k = 0; k < 1700; k++) pending_items.push_back(random_item());

    rst_n = 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    while (pending_items.size() > 0 || in_valid || expected_results.size() > 0) begin
      @(posedge clk);
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("CHECKS FAILED");
        $finish;
      end
    end
    repeat (100) @(posedge clk);
    if (error_count == 0 && expected_results.size() == 0 && !out_valid) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end
endmodule
